// File: hw/rtl/hcs_pkg.sv
// Shared types and constants for the hop channel sequencer.
// Used by hcs_ctrl, hcs_datapath and hop_channel_sequencer; depends on nothing.

package hcs_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int QUEUE_SLOTS   = 4;
    localparam int QUEUE_AW      = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int HOP_W         = 7;
    localparam int BEACON_MAX    = 127;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_LOAD   = 3'd1;
    localparam logic [2:0] CMD_MODE   = 3'd2;
    localparam logic [2:0] CMD_QUEUE  = 3'd3;
    localparam logic [2:0] CMD_MANUAL = 3'd4;

    // Link modes
    localparam logic [2:0] MODE_NONHOP    = 3'd0;
    localparam logic [2:0] MODE_DISCOVERY = 3'd1;
    localparam logic [2:0] MODE_SEEKING   = 3'd2;
    localparam logic [2:0] MODE_SYNCHED   = 3'd3;
    localparam logic [2:0] MODE_BEACON    = 3'd4;
    localparam logic [2:0] MODE_MASTER    = 3'd5;

    // Configuration register indexes
    localparam logic REG_HOP_THRESHOLD = 1'b0;
    localparam logic REG_NUM_HOPS      = 1'b1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] index;
        logic [7:0] value;
        logic [7:0] msg_len;
    } item_t;

    typedef struct packed {
        logic [7:0] channel;
        logic       hopped;
        logic       beacon;
        logic [5:0] beacon_index;
        logic       send;
        logic [1:0] send_slot;
        logic [7:0] send_len;
        logic [2:0] mode;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;      // apply the accepted item to the state
        logic rd_en;     // read the table at the new hop index
        logic out_load;  // move the finished result to the output register
    } ctrl_cmd_t;

endpackage

// File: hw/rtl/hop_channel_sequencer.sv
// Top level of the hop channel sequencer: joins controller and datapath.
// Depends on hcs_pkg, hcs_ctrl and hcs_datapath.

// Each accepted item gives one result. An item is taken, the state is updated
// at that edge, the channel table (a registered-read memory) is read at the
// new hop index in the next cycle, and the result enters the output register
// once that register is free; item_ready returns in the cycle after that.
// The next item may be accepted while the previous result still waits in the
// output register. Configuration writes on cfg_we take effect at once and
// belong between items.

module hop_channel_sequencer
    import hcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    ctrl_cmd_t ctrl;

    hcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ctrl         (ctrl)
    );

    hcs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

`ifndef SYNTH
    // Only one item is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in flight");

    // Beacons and sends happen only on a hop.
    a_events_on_hop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.hopped |-> !result.beacon && !result.send)
        else $error("beacon or send without a hop");

    a_beacon_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.beacon |->
            result.mode == MODE_BEACON || result.mode == MODE_MASTER)
        else $error("beacon outside beacon-master mode");

    a_send_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.send |-> result.send_len != 8'd0)
        else $error("empty queue slot sent");
`endif

endmodule

// File: hw/rtl/hcs_ctrl.sv
// Controller of the hop channel sequencer: sequences execute, table read and
// result hand-off, and owns both handshakes. Depends on hcs_pkg.

module hcs_ctrl
    import hcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    output logic      result_valid,
    input  logic      result_ready,
    output ctrl_cmd_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        ctrl              = '0;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.exec  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The output register may still hold the previous result.
                if (!result_valid_reg || result_ready)
                begin
                    ctrl.out_load     = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// File: hw/rtl/hcs_datapath.sv
// Datapath of the hop channel sequencer: channel table memory, hop and tick
// counters, mode, beacon count, message queue and result registers. Depends on hcs_pkg.

module hcs_datapath
    import hcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  ctrl,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output result_t    result
);

    logic [7:0]        channel_mem [TABLE_ENTRIES];
    logic [7:0]        rdata_reg;

    logic [7:0]        hop_threshold_reg;
    logic [HOP_W-1:0]  num_hops_reg;

    logic [TBL_AW-1:0] hop_index_reg,    hop_index_next;
    logic [7:0]        tick_count_reg,   tick_count_next;
    logic [2:0]        link_mode_reg,    link_mode_next;
    logic [6:0]        beacons_sent_reg, beacons_sent_next;
    logic [7:0]        queue_len_reg [QUEUE_SLOTS];
    logic [7:0]        queue_len_next [QUEUE_SLOTS];
    logic [QUEUE_AW-1:0] write_ptr_reg,  write_ptr_next;
    logic [QUEUE_AW-1:0] send_ptr_reg,   send_ptr_next;

    result_t           pend_reg, pend_next;
    result_t           result_reg, result_next;

    logic [HOP_W-1:0]  hop_len;
    logic [HOP_W-1:0]  hop_inc;
    logic [8:0]        tick_inc;
    logic [QUEUE_AW:0] send_inc;
    logic [QUEUE_AW:0] write_inc;
    logic [7:0]        slot_len;
    logic [2:0]        mode_mid;
    logic [6:0]        beacons_mid;

    assign hop_len   = (num_hops_reg < HOP_W'(TABLE_ENTRIES)) ? num_hops_reg
                                                             : HOP_W'(TABLE_ENTRIES);
    assign hop_inc   = HOP_W'(hop_index_reg) + HOP_W'(1);
    assign tick_inc  = {1'b0, tick_count_reg} + 9'd1;
    assign send_inc  = {1'b0, send_ptr_reg} + (QUEUE_AW+1)'(1);
    assign write_inc = {1'b0, write_ptr_reg} + (QUEUE_AW+1)'(1);
    assign slot_len  = queue_len_reg[send_ptr_reg];

    always_comb
    begin
        hop_index_next    = hop_index_reg;
        tick_count_next   = tick_count_reg;
        mode_mid          = link_mode_reg;
        beacons_mid       = beacons_sent_reg;
        write_ptr_next    = write_ptr_reg;
        send_ptr_next     = send_ptr_reg;
        queue_len_next    = queue_len_reg;
        pend_next         = '0;
        link_mode_next    = link_mode_reg;
        beacons_sent_next = beacons_sent_reg;

        unique case (item.cmd)
            CMD_TICK:
            begin
                if (tick_inc >= {1'b0, hop_threshold_reg})
                begin
                    tick_count_next  = '0;
                    hop_index_next   = (hop_inc >= hop_len) ? '0 : hop_inc[TBL_AW-1:0];
                    pend_next.hopped = 1'b1;
                    if (link_mode_reg == MODE_BEACON)
                    begin
                        pend_next.beacon       = 1'b1;
                        pend_next.beacon_index = hop_index_next;
                        if (beacons_sent_reg < 7'(BEACON_MAX))
                        begin
                            beacons_mid = beacons_sent_reg + 7'd1;
                        end
                    end
                    else if ((link_mode_reg == MODE_SYNCHED ||
                              link_mode_reg == MODE_MASTER) && slot_len != 8'd0)
                    begin
                        pend_next.send             = 1'b1;
                        pend_next.send_slot        = 2'(send_ptr_reg);
                        pend_next.send_len         = slot_len;
                        queue_len_next[send_ptr_reg] = 8'd0;
                        send_ptr_next = (send_inc >= (QUEUE_AW+1)'(QUEUE_SLOTS))
                                        ? '0 : send_inc[QUEUE_AW-1:0];
                    end
                end
                else
                begin
                    tick_count_next = tick_inc[7:0];
                end
            end
            CMD_LOAD:
            begin
                // The table write itself happens in the memory block below.
            end
            CMD_MODE:
            begin
                if (item.value <= 8'(MODE_MASTER))
                begin
                    mode_mid = item.value[2:0];
                    if (item.value[2:0] == MODE_BEACON)
                    begin
                        beacons_mid = '0;
                    end
                end
            end
            CMD_QUEUE:
            begin
                queue_len_next[write_ptr_reg] = item.msg_len;
                write_ptr_next = (write_inc >= (QUEUE_AW+1)'(QUEUE_SLOTS))
                                 ? '0 : write_inc[QUEUE_AW-1:0];
            end
            CMD_MANUAL:
            begin
                hop_index_next   = (hop_inc >= HOP_W'(TABLE_ENTRIES)) ? '0
                                                                     : hop_inc[TBL_AW-1:0];
                pend_next.hopped = 1'b1;
            end
            default:
            begin
            end
        endcase

        // A full loop of beacons promotes the link to master.
        if (mode_mid == MODE_BEACON && {1'b0, beacons_mid} >= {1'b0, hop_len})
        begin
            link_mode_next = MODE_MASTER;
        end
        else
        begin
            link_mode_next = mode_mid;
        end
        beacons_sent_next = beacons_mid;
        pend_next.mode    = link_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_threshold_reg <= '0;
            num_hops_reg      <= HOP_W'(TABLE_ENTRIES);
            hop_index_reg     <= '0;
            tick_count_reg    <= '0;
            link_mode_reg     <= MODE_NONHOP;
            beacons_sent_reg  <= '0;
            write_ptr_reg     <= '0;
            send_ptr_reg      <= '0;
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                queue_len_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_HOP_THRESHOLD: hop_threshold_reg <= cfg_data;
                    REG_NUM_HOPS:      num_hops_reg      <= cfg_data[HOP_W-1:0];
                    default:           ;
                endcase
            end
            if (ctrl.exec)
            begin
                hop_index_reg    <= hop_index_next;
                tick_count_reg   <= tick_count_next;
                link_mode_reg    <= link_mode_next;
                beacons_sent_reg <= beacons_sent_next;
                write_ptr_reg    <= write_ptr_next;
                send_ptr_reg     <= send_ptr_next;
                queue_len_reg    <= queue_len_next;
            end
        end
    end

    // Channel table: written on a load transfer, read once the hop index has settled.
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && item.cmd == CMD_LOAD &&
            {1'b0, item.index} < (TBL_AW+1)'(TABLE_ENTRIES))
        begin
            channel_mem[item.index[TBL_AW-1:0]] <= item.value;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= channel_mem[hop_index_reg];
        end
    end

    always_comb
    begin
        result_next         = pend_reg;
        result_next.channel = rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            pend_reg <= pend_next;
        end
        if (ctrl.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: sim/tb_hop_channel_sequencer.sv
// Self-checking testbench for hop_channel_sequencer: directed tests, then random traffic.
// A predictor in the testbench models every transfer; uses hcs_pkg and the RTL only.

module tb_hop_channel_sequencer;
    import hcs_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 30;

    // Command codes the block does not define.
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    // Receiver stall styles.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_MOSTLY   = 2;
    localparam int RX_PERIODIC = 3;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    item_t      item;
    logic       result_valid;
    logic       result_ready;
    result_t    result;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    hop_channel_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predicted state of the sequencer.
    logic [7:0]          chan_tbl [TABLE_ENTRIES];
    logic [TBL_AW-1:0]   hop_idx;
    logic [7:0]          tick_cnt;
    logic [2:0]          link_mode;
    logic [HOP_W-1:0]    beacon_cnt;
    logic [7:0]          q_len [QUEUE_SLOTS];
    logic [QUEUE_AW-1:0] wr_ptr;
    logic [QUEUE_AW-1:0] tx_ptr;
    logic [7:0]          dwell_ticks;
    logic [HOP_W-1:0]    n_hops;

    result_t expected_results [$];

    int error_count;
    int items_in;
    int results_out;
    int cfg_writes;
    int hop_total;
    int beacon_total;
    int send_total;
    int cycle_count;
    int hold_asked;
    int hold_served;
    int burst_left;
    bit gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic void reset_prediction();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            chan_tbl[i] = '0;
        for (int i = 0; i < QUEUE_SLOTS; i++)
            q_len[i] = '0;
        hop_idx     = '0;
        tick_cnt    = '0;
        link_mode   = MODE_NONHOP;
        beacon_cnt  = '0;
        wr_ptr      = '0;
        tx_ptr      = '0;
        dwell_ticks = '0;
        n_hops      = 7'd64;
    endfunction

    function automatic int seq_length();
        return (int'(n_hops) < TABLE_ENTRIES) ? int'(n_hops) : TABLE_ENTRIES;
    endfunction

    function automatic result_t hop_predict(item_t it);
        result_t r;
        r = '0;
        case (it.cmd)
            CMD_TICK:
            begin
                if (int'(tick_cnt) + 1 >= int'(dwell_ticks))
                begin
                    tick_cnt = '0;
                    if (int'(hop_idx) + 1 >= seq_length())
                        hop_idx = '0;
                    else
                        hop_idx = hop_idx + 1'b1;
                    r.hopped = 1'b1;
                    if (link_mode == MODE_BEACON)
                    begin
                        r.beacon       = 1'b1;
                        r.beacon_index = hop_idx;
                        if (int'(beacon_cnt) < BEACON_MAX)
                            beacon_cnt = beacon_cnt + 1'b1;
                    end
                    else if (link_mode == MODE_SYNCHED || link_mode == MODE_MASTER)
                    begin
                        // Only the slot under the read pointer is looked at.
                        if (q_len[tx_ptr] != 0)
                        begin
                            r.send      = 1'b1;
                            r.send_slot = tx_ptr;
                            r.send_len  = q_len[tx_ptr];
                            q_len[tx_ptr] = '0;
                            tx_ptr = tx_ptr + 1'b1;
                        end
                    end
                end
                else
                begin
                    tick_cnt = tick_cnt + 1'b1;
                end
            end
            CMD_LOAD:
                chan_tbl[it.index] = it.value;
            CMD_MODE:
            begin
                if (it.value <= MODE_MASTER)
                begin
                    link_mode = it.value[2:0];
                    if (it.value == MODE_BEACON)
                        beacon_cnt = '0;
                end
            end
            CMD_QUEUE:
            begin
                q_len[wr_ptr] = it.msg_len;
                wr_ptr = wr_ptr + 1'b1;
            end
            CMD_MANUAL:
            begin
                hop_idx  = hop_idx + 1'b1;
                r.hopped = 1'b1;
            end
            default:
                ;
        endcase
        if (link_mode == MODE_BEACON && int'(beacon_cnt) >= seq_length())
            link_mode = MODE_MASTER;
        r.channel = chan_tbl[hop_idx];
        r.mode    = link_mode;
        return r;
    endfunction

    task automatic field_diff(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            $display("%0t   %s: expected %0d, got %0d", $time, name, want, got);
    endtask

    task automatic check_result(result_t want, result_t got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
            begin
                $display("%0t: result %0d mismatch, expected %h, got %h",
                         $time, results_out, want, got);
                field_diff("channel", want.channel, got.channel);
                field_diff("hopped", want.hopped, got.hopped);
                field_diff("beacon", want.beacon, got.beacon);
                field_diff("beacon_index", want.beacon_index, got.beacon_index);
                field_diff("send", want.send, got.send);
                field_diff("send_slot", want.send_slot, got.send_slot);
                field_diff("send_len", want.send_len, got.send_len);
                field_diff("mode", want.mode, got.mode);
            end
        end
    endtask

    // One process sees both channels and the register port, so the order of
    // checking and predicting within an edge is fixed.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_out++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected, got %h",
                                 $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_result(want, result);
                end
            end
            if (cfg_we)
            begin
                cfg_writes++;
                if (cfg_index == REG_HOP_THRESHOLD)
                    dwell_ticks = cfg_data;
                else
                    n_hops = cfg_data[HOP_W-1:0];
            end
            if (item_valid && item_ready)
            begin
                want = hop_predict(item);
                expected_results.push_back(want);
                items_in++;
                hop_total    += want.hopped;
                beacon_total += want.beacon;
                send_total   += want.send;
            end
        end
    end

    // Receiver: changes its stall style every so often, and on request holds
    // off for a long stretch so the block backs up.
    initial
    begin : receiver
        int rx_style;
        int style_left;
        int pat_phase;
        rx_style   = RX_ALWAYS;
        style_left = 0;
        pat_phase  = 0;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_served != hold_asked)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
            begin
                if (style_left == 0)
                begin
                    rx_style   = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                    style_left = $urandom_range(32, 200);
                end
                style_left--;
                pat_phase = (pat_phase + 1) % 7;
                case (rx_style)
                    RX_ALWAYS:   result_ready <= 1'b1;
                    RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   result_ready <= ($urandom_range(0, 7) != 0);
                    default:     result_ready <= (pat_phase < 3);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("tb_hop_channel_sequencer: done, errors");
        $finish;
    end

    function automatic item_t make_item(logic [2:0] c, logic [5:0] idx, logic [7:0] v,
                                        logic [7:0] len);
        item_t it;
        it.cmd     = c;
        it.index   = idx;
        it.value   = v;
        it.msg_len = len;
        return it;
    endfunction

    function automatic item_t random_item(bit sweep);
        item_t it;
        int    pick;
        it.index   = 6'($urandom_range(0, 63));
        it.value   = 8'($urandom_range(0, 255));
        it.msg_len = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (sweep)
            it.cmd = (pick < 60) ? CMD_MANUAL : (pick < 90) ? CMD_TICK : CMD_QUEUE;
        else if (pick < 45)
            it.cmd = CMD_TICK;
        else if (pick < 57)
            it.cmd = CMD_LOAD;
        else if (pick < 68)
        begin
            it.cmd = CMD_MODE;
            pick = $urandom_range(0, 99);
            // Mostly the modes where hops carry beacons or messages.
            if (pick < 55)
                it.value = 8'($urandom_range(MODE_SYNCHED, MODE_MASTER));
            else if (pick < 88)
                it.value = 8'($urandom_range(MODE_NONHOP, MODE_MASTER));
        end
        else if (pick < 83)
            it.cmd = CMD_QUEUE;
        else if (pick < 95)
            it.cmd = CMD_MANUAL;
        else
            it.cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        return it;
    endfunction

    // Valid stays high between back-to-back items; only a gap lowers it.
    task automatic send_item(item_t it);
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_paced(item_t it);
        if (burst_left == 0)
        begin
            if (gaps_on)
                pause_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Only called once the block is idle.
    task automatic set_config(logic [7:0] thr_v, logic [HOP_W-1:0] hops_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOP_THRESHOLD;
        cfg_data  <= thr_v;
        @(posedge clk);
        cfg_index <= REG_NUM_HOPS;
        cfg_data  <= {1'b0, hops_v};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Every entry is loaded first, entry zero before all others, so no result
    // ever reports an entry that was never written.
    task automatic test_table_fill();
        logic [7:0] v;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            v = (i == 0) ? 8'h00 : (i == TABLE_ENTRIES - 1) ? 8'hFF : 8'($urandom_range(0, 255));
            send_item(make_item(CMD_LOAD, 6'(i), v, 8'($urandom_range(0, 255))));
        end
        wait_idle();
    endtask

    task automatic test_basic_hops();
        set_config(8'd0, 7'd3);
        repeat (3) send_item(make_item(CMD_TICK, 6'd63, 8'hFF, 8'hFF));
        send_item(make_item(CMD_QUEUE, 6'd0, 8'd0, 8'd255));
        send_item(make_item(CMD_QUEUE, 6'd63, 8'd255, 8'd0));
    endtask

    task automatic test_queue_send();
        send_item(make_item(CMD_MODE, 6'd0, 8'(MODE_SYNCHED), 8'd0));
        send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
        send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
    endtask

    task automatic test_odd_commands();
        send_item(make_item(CMD_MODE, 6'd5, 8'(MODE_MASTER) + 8'd1, 8'd7));
        send_item(make_item(CMD_MODE, 6'd5, 8'hFF, 8'd7));
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
            send_item(make_item(3'(c), 6'd63, 8'hAA, 8'h55));
    endtask

    task automatic test_beacon_master();
        send_item(make_item(CMD_MODE, 6'd0, 8'(MODE_BEACON), 8'd0));
        repeat (3) send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
        send_item(make_item(CMD_MANUAL, 6'd0, 8'd0, 8'd0));
    endtask

    // The threshold drops below the running count: the next tick hops at once.
    task automatic test_threshold_drop();
        wait_idle();
        set_config(8'd10, 7'd3);
        repeat (4) send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
        wait_idle();
        set_config(8'd2, 7'd3);
        send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
    endtask

    // Zero hop length pins ticks to entry zero; an oversized one acts as 64.
    task automatic test_hop_length_edges();
        wait_idle();
        set_config(8'd1, 7'd0);
        send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
        send_item(make_item(CMD_MANUAL, 6'd0, 8'd0, 8'd0));
        send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
        wait_idle();
        set_config(8'd0, 7'd100);
        repeat (2) send_item(make_item(CMD_TICK, 6'd0, 8'd0, 8'd0));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0]       thr_v;
        logic [HOP_W-1:0] hops_v;
        int               count;
        bit               sweep;
        for (int p = 0; p < 12; p++)
        begin
            thr_v  = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(5, 20))
                                                 : 8'($urandom_range(0, 4));
            hops_v = 7'($urandom_range(1, 64));
            count  = 115;
            sweep  = 1'b0;
            case (p)
                0: begin thr_v = 8'd0;   hops_v = 7'd64; end
                1: begin thr_v = 8'd1;   hops_v = 7'd1;  end
                2: begin thr_v = 8'd255; hops_v = 7'd64; count = 40; end
                3: begin thr_v = 8'd0;   hops_v = 7'd0;  end
                4: begin thr_v = 8'd2;   hops_v = 7'd100; end
                5: begin thr_v = 8'd3;   hops_v = 7'd64; sweep = 1'b1; end
                default: ;
            endcase
            wait_idle();
            set_config(thr_v, hops_v);
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            for (int i = 0; i < count; i++)
                send_paced(random_item(sweep));
        end
        wait_idle();
    endtask

    // The receiver holds off while items keep coming, so the block fills and
    // stops taking transfers; then the sender waits for every result.
    task automatic test_backpressure();
        wait_idle();
        set_config(8'd1, 7'd16);
        hold_asked++;
        for (int i = 0; i < 40; i++)
            send_item(random_item(1'b0));
        wait_idle();
    endtask

    initial
    begin : main
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_HOP_THRESHOLD;
        cfg_data    = '0;
        error_count = 0;
        items_in    = 0;
        results_out = 0;
        cfg_writes  = 0;
        hop_total   = 0;
        beacon_total = 0;
        send_total  = 0;
        hold_asked  = 0;
        hold_served = 0;
        burst_left  = 0;
        gaps_on     = 1'b0;
        reset_prediction();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_basic_hops();
        test_queue_send();
        test_odd_commands();
        test_beacon_master();
        test_threshold_drop();
        test_hop_length_edges();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            error_count++;

        $display("Run covered %0d item transfers and %0d result transfers, %0d register writes,",
                 items_in, results_out, cfg_writes);
        $display("with %0d hops, %0d beacons and %0d message sends, in %0d cycles.",
                 hop_total, beacon_total, send_total, cycle_count);
        if (error_count == 0)
            $display("tb_hop_channel_sequencer: done, clean");
        else
            $display("tb_hop_channel_sequencer: done, errors");
        $finish;
    end

endmodule

// File: hop_channel_sequencer.f
hw/rtl/hcs_pkg.sv
hw/rtl/hcs_ctrl.sv
hw/rtl/hcs_datapath.sv
hw/rtl/hop_channel_sequencer.sv
sim/tb_hop_channel_sequencer.sv
